[rtl/core/b2da_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII emitter.
// Used by b2da_cell, binary_to_decimal_ascii_emitter and the testbench; depends on nothing.

package b2da_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned ASCII_W = 6;
    localparam int unsigned CNT_W   = 5;

    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

    // Control word broadcast to every digit cell.
    typedef struct packed {
        logic clr;
        logic dabble;
        logic emit;
    } t_cell_ctl;

    // Power of ten, evaluated at elaboration only.
    function automatic logic [63:0] pow10(input int unsigned e);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < e; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

[rtl/core/binary_to_decimal_ascii_emitter.sv]
`timescale 1ns / 1ps
// Top level of the binary to decimal ASCII emitter: control and digit chain.
// Depends on b2da_pkg and b2da_cell.
//
// Usage: drive i_value and raise start while busy is low; the word is taken
// at that clock edge. Values above 10^NUM_DIGITS - 1 are saturated to that
// limit and every digit of that word carries o_overflow.
// The value is shifted bit by bit into a chain of NUM_DIGITS BCD cells
// (shift-and-add-three), then the chain shifts its digits toward the top
// cell, one digit per cycle, most significant first.
// Leading zeros are dropped, so a word yields 1 to NUM_DIGITS digits; the
// least significant one has o_last set. A zero value gives a single '0'.
// Each digit appears on o_ascii_digit for exactly one cycle with o_strobe
// high. busy stays high through the bit shift and the digit shifts of each
// word. The next word may be started in the cycle busy falls.
// The receiver has no way to stall the digit stream.
// Reset (i_rst_n low, synchronous) returns the block to idle and drops the
// strobe; any word in progress is abandoned.

module binary_to_decimal_ascii_emitter
    import b2da_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               busy,
    output logic               o_strobe,
    output logic [ASCII_W-1:0] o_ascii_digit,
    output logic               o_last,
    output logic               o_overflow
);

    localparam logic [63:0]      LIMIT     = pow10(NUM_DIGITS) - 64'd1;
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [CNT_W-1:0] EMIT_LAST = CNT_W'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_bin;
    logic               r_ovf;
    logic               r_started;

    t_cell_ctl          cell_ctl;
    logic               accept;
    logic               ovf_in;
    logic [VALUE_W-1:0] sat_value;
    logic [DIGIT_W-1:0] top_digit;
    logic               is_last;
    logic               show;

    // Carry and digit links between neighbors; index 0 feeds the lowest cell.
    // While converting, the carry out of the top cell is zero after saturation.
    logic               carry [NUM_DIGITS+1];
    logic [DIGIT_W-1:0] digit [NUM_DIGITS+1];

    assign accept    = start && (r_state == ST_IDLE);
    assign busy      = (r_state != ST_IDLE);
    assign ovf_in    = ({32'd0, i_value} > LIMIT);
    assign sat_value = ovf_in ? LIMIT[VALUE_W-1:0] : i_value;

    assign cell_ctl.clr    = (r_state == ST_IDLE);
    assign cell_ctl.dabble = (r_state == ST_CONV);
    assign cell_ctl.emit   = (r_state == ST_EMIT);

    assign carry[0] = r_bin[VALUE_W-1];
    assign digit[0] = '0;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        b2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_carry (carry[g]),
            .i_digit (digit[g]),
            .o_carry (carry[g+1]),
            .o_digit (digit[g+1])
        );
    end

    assign top_digit = digit[NUM_DIGITS];
    assign is_last   = (r_cnt == EMIT_LAST);
    assign show      = (top_digit != '0) || r_started || is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_started <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_cnt     <= '0;
                    r_started <= 1'b0;
                    if (accept) begin
                        r_bin   <= sat_value;
                        r_ovf   <= ovf_in;
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                    if (r_cnt == CONV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (show) begin
                        r_started     <= 1'b1;
                        o_strobe      <= 1'b1;
                        o_ascii_digit <= ASCII_ZERO + {2'b00, top_digit};
                        o_last        <= is_last;
                        o_overflow    <= r_ovf;
                    end
                    if (is_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/b2da_cell.sv]
`timescale 1ns / 1ps
// One BCD digit cell of the conversion chain.
// Depends on b2da_pkg for the control word and widths.

module b2da_cell
    import b2da_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_carry,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    // Add three to a digit of five or more so that the left shift carries into
    // the next decade.
    assign adj     = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctl.emit) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Testbench for binary_to_decimal_ascii_emitter: random and edge-case values in,
// every emitted ASCII digit checked against a digit-by-digit prediction.
// Depends on b2da_pkg and the emitter RTL.

module testbench;
    import b2da_pkg::*;

    localparam int unsigned NUM_DIGITS  = 8;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 45;
    localparam int unsigned RAND_VALUES = 405;

    typedef struct packed {
        logic [ASCII_W-1:0] code;
        logic               is_last;
        logic               ovf;
    } t_digit;

    class digit_scoreboard;
        t_digit expected_digits[$];
        int     mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string msg);
            if (mismatch_count < 100)
                $display("[%0t] digit mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Queues the digits of one accepted word, most significant first.
        function void note_value(input logic [VALUE_W-1:0] value);
            logic [63:0] rest;
            logic [63:0] weight;
            logic [63:0] ceiling;
            logic [3:0]  d;
            logic        started;
            logic        sat;
            t_digit      item;
            ceiling = 64'd1;
            for (int i = 0; i < NUM_DIGITS; i++) ceiling = ceiling * 64'd10;
            weight  = ceiling / 64'd10;
            ceiling = ceiling - 64'd1;
            sat     = (64'(value) > ceiling);
            rest    = sat ? ceiling : 64'(value);
            started = 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                d = 4'd0;
                while (rest >= weight && d < 4'd9) begin
                    rest = rest - weight;
                    d    = d + 4'd1;
                end
                if (d != 4'd0 || started || weight == 64'd1) begin
                    started      = 1'b1;
                    item.code    = ASCII_ZERO + ASCII_W'(d);
                    item.is_last = (weight == 64'd1);
                    item.ovf     = sat;
                    expected_digits.push_back(item);
                end
                weight = weight / 64'd10;
            end
        endfunction

        task check_digit(input logic [ASCII_W-1:0] code, input logic is_last,
                         input logic ovf);
            t_digit want;
            if (expected_digits.size() == 0) begin
                report_mismatch($sformatf("digit 0x%h with no word pending", code));
                return;
            end
            want = expected_digits.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("code 0x%h, wanted 0x%h", code, want.code));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("last %b, wanted %b (code 0x%h)",
                                          is_last, want.is_last, want.code));
            if (ovf !== want.ovf)
                report_mismatch($sformatf("overflow %b, wanted %b (code 0x%h)",
                                          ovf, want.ovf, want.code));
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               busy;
    logic               o_strobe;
    logic [ASCII_W-1:0] o_ascii_digit;
    logic               o_last;
    logic               o_overflow;

    digit_scoreboard digits;
    int unsigned     quiet_run = 0;
    int unsigned     stall_cycles = 0;

    binary_to_decimal_ascii_emitter #(
        .NUM_DIGITS(NUM_DIGITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .busy         (busy),
        .o_strobe     (o_strobe),
        .o_ascii_digit(o_ascii_digit),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            digits.check_digit(o_ascii_digit, o_last, o_overflow);
    end

    // Ends the run if neither a word is taken nor a digit comes out for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Holds start high until the block takes the word. A zero gap keeps start
    // high straight through, so back-to-back words never drop it.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = (quiet_run > 0) ? 0 : $urandom_range(0, 15);
        if (quiet_run > 0)
            quiet_run--;
        else if ($urandom_range(0, 15) == 0)
            quiet_run = $urandom_range(4, 16);
        if (gap > 0) begin
            start   <= 1'b0;
            i_value <= $urandom;
            // Half the time the gap counts from the end of the previous word.
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        digits.note_value(value);
    endtask

    // Sampling at the falling edge keeps this clear of the monitor's updates.
    task automatic wait_for_digits();
        start <= 1'b0;
        do @(negedge i_clk); while (digits.expected_digits.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [VALUE_W-1:0] directed_values[$];
        logic [VALUE_W-1:0] v;
        int unsigned        span;
        int unsigned        k;

        digits = new();
        directed_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd50, 32'd99, 32'd100,
                            32'd1000, 32'd9999999, 32'd10000000, 32'd10000001,
                            32'd12345678, 32'd10203040, 32'd20000000, 32'd90000000,
                            32'd98765432, 32'd99999998, 32'd99999999, 32'd100000000,
                            32'd100000001, 32'h8000_0000, 32'hFFFF_FFFF, 32'd7};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_values[i]) send_value(directed_values[i]);
        wait_for_digits();

        for (int n = 0; n < RAND_VALUES; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // Any length from one to eight digits.
                    k    = $urandom_range(1, NUM_DIGITS);
                    span = 1;
                    repeat (k) span = span * 10;
                    v    = $urandom_range(0, span - 1);
                end
                4: v = $urandom;
                5, 6: begin
                    // Just around a power of ten.
                    k    = $urandom_range(0, NUM_DIGITS);
                    span = 1;
                    repeat (k) span = span * 10;
                    v    = span + $urandom_range(0, 2) - 1;
                end
                7, 8: begin
                    // Mostly zero digits, inside and at the end of the number.
                    v = '0;
                    repeat (NUM_DIGITS)
                        v = v * 10 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0);
                end
                default: v = 32'd99999999 + $urandom_range(0, 6) - 3;
            endcase
            send_value(v);
            if (n == 100 || $urandom_range(0, 63) == 0)
                wait_for_digits();
        end

        wait_for_digits();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (digits.expected_digits.size() != 0)
            digits.report_mismatch($sformatf("%0d digits never came",
                                             digits.expected_digits.size()));
        if (digits.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
